[src/list_move_reorder_engine_assert.svh]
// Assertion macros shared by the list reorder engine.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LIST_MOVE_REORDER_ENGINE_ASSERT_SVH
`define LIST_MOVE_REORDER_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMRE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/lmre_pkg.sv]
// Shared types for the list reorder engine: operation codes and the
// command and status bundles between controller and datapath. No dependencies.
package lmre_pkg;

	typedef enum logic [1:0] {
		OP_FRONT = 2'd0,
		OP_BACK  = 2'd1,
		OP_AFTER = 2'd2,
		OP_READ  = 2'd3
	} lmre_op_t;

	typedef struct packed {
		logic cfg_load;
		logic sweep_step;
		logic accept;
		logic rd_list;
		logic rd_wx;
		logic rd_wy;
		logic latch_ix;
		logic plan;
		logic shift;
		logic place;
		logic finish;
	} lmre_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic err;
		logic is_read;
		logic is_after;
		logic noop;
		logic shift_done;
		logic out_free;
	} lmre_stat_t;

endpackage

[src/lmre_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lmre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/lmre_ctrl.sv]
// Controller state machine of the list reorder engine.
// Uses lmre_pkg for the command and status bundles.
module lmre_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cfg_wr,
	input  lmre_pkg::lmre_stat_t stat,
	output lmre_pkg::lmre_cmd_t  cmd,
	output logic               in_stall
);

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DECODE,
		ST_LOCX,
		ST_LOCY,
		ST_SHIFT,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = (state_q != ST_IDLE) || cfg_wr;
		if (cfg_wr) begin
			// A register write always restarts the reload of the list.
			cmd.cfg_load = 1'b1;
			state_nxt    = ST_SWEEP;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					cmd.sweep_step = 1'b1;
					if (stat.sweep_last) begin
						state_nxt = ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_nxt  = ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (stat.err || stat.noop) begin
						state_nxt = ST_DONE;
					end else if (stat.is_read) begin
						cmd.rd_list = 1'b1;
						state_nxt   = ST_READ;
					end else begin
						cmd.rd_wx = 1'b1;
						state_nxt = ST_LOCX;
					end
				end
				ST_LOCX: begin
					if (stat.is_after) begin
						cmd.latch_ix = 1'b1;
						cmd.rd_wy    = 1'b1;
						state_nxt    = ST_LOCY;
					end else begin
						cmd.plan  = 1'b1;
						state_nxt = ST_SHIFT;
					end
				end
				ST_LOCY: begin
					cmd.plan  = 1'b1;
					state_nxt = ST_SHIFT;
				end
				ST_SHIFT: begin
					if (stat.shift_done) begin
						cmd.place = 1'b1;
						state_nxt = ST_DONE;
					end else begin
						cmd.shift = 1'b1;
					end
				end
				ST_READ: begin
					state_nxt = ST_DONE;
				end
				ST_DONE: begin
					if (stat.out_free) begin
						cmd.finish = 1'b1;
						state_nxt  = ST_IDLE;
					end
				end
				default: begin
					state_nxt = ST_SWEEP;
				end
			endcase
		end
	end

endmodule

[src/lmre_dp.sv]
// Datapath of the list reorder engine: the list RAM, the inverse (id to position)
// RAM, shift pointers and the output register. Uses lmre_pkg and lmre_ram.
module lmre_dp #(
	parameter int MAX_ITEMS = 1024,
	localparam int ID_W  = $clog2(MAX_ITEMS + 1),
	localparam int POS_W = $clog2(MAX_ITEMS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lmre_pkg::lmre_cmd_t  cmd,
	output lmre_pkg::lmre_stat_t stat,
	input  logic [ID_W-1:0]      cfg_data,
	input  logic [1:0]           opcode,
	input  logic [ID_W-1:0]      first_item,
	input  logic [ID_W-1:0]      second_item,
	input  logic [POS_W-1:0]     position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ID_W-1:0]      item_at_position,
	output logic                 status
);

	localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_ITEMS);

	logic [ID_W-1:0]  active_q;
	logic [POS_W-1:0] sweep_ptr_q;
	lmre_pkg::lmre_op_t op_q;
	logic [ID_W-1:0]  x_q;
	logic [ID_W-1:0]  y_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] ix_q;
	logic [POS_W-1:0] dst_q;
	logic [POS_W-1:0] rd_ptr_q;
	logic [POS_W-1:0] cnt_q;
	logic             up_q;
	logic             v_s1;
	logic [POS_W-1:0] wa_s1;
	logic             out_valid_q;
	logic [ID_W-1:0]  item_q;
	logic             status_q;

	logic [ID_W-1:0]  cfg_clamped;
	logic             x_ok;
	logic             y_ok;
	logic             pos_ok;
	logic             err;
	logic [POS_W-1:0] last_pos;

	logic             list_we;
	logic [POS_W-1:0] list_waddr;
	logic [ID_W-1:0]  list_wdata;
	logic             list_re;
	logic [POS_W-1:0] list_raddr;
	logic [ID_W-1:0]  list_rdata;
	logic             where_we;
	logic [POS_W-1:0] where_waddr;
	logic [POS_W-1:0] where_wdata;
	logic             where_re;
	logic [POS_W-1:0] where_raddr;
	logic [POS_W-1:0] where_rdata;

	logic [POS_W-1:0] plan_src;
	logic [POS_W-1:0] plan_dst;
	logic             plan_up;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = ID_W'(1);
		end else if (cfg_data > MAX_ID) begin
			cfg_clamped = MAX_ID;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	assign last_pos = POS_W'(active_q - ID_W'(1));
	assign x_ok     = (x_q != '0) && (x_q <= active_q);
	assign y_ok     = (y_q != '0) && (y_q <= active_q);
	assign pos_ok   = ID_W'(pos_q) < active_q;
	assign err      = (op_q == lmre_pkg::OP_READ) ? !pos_ok
		: (!x_ok || ((op_q == lmre_pkg::OP_AFTER) && !y_ok));

	assign stat.sweep_last = (sweep_ptr_q == last_pos);
	assign stat.err        = err;
	assign stat.is_read    = (op_q == lmre_pkg::OP_READ);
	assign stat.is_after   = (op_q == lmre_pkg::OP_AFTER);
	assign stat.noop       = (op_q == lmre_pkg::OP_AFTER) && (x_q == y_q);
	assign stat.shift_done = (cnt_q == '0) && !v_s1;
	assign stat.out_free   = !out_valid_q || !out_stall;

	// Read side: the list is read at the shift pointer or the requested position,
	// the inverse table at the moved item or the anchor.
	assign list_re     = cmd.rd_list || (cmd.shift && (cnt_q != '0));
	assign list_raddr  = cmd.shift ? rd_ptr_q : pos_q;
	assign where_re    = cmd.rd_wx || cmd.rd_wy;
	assign where_raddr = cmd.rd_wy ? POS_W'(y_q - ID_W'(1)) : POS_W'(x_q - ID_W'(1));

	always_comb begin
		list_we     = 1'b0;
		list_waddr  = wa_s1;
		list_wdata  = list_rdata;
		where_we    = 1'b0;
		where_waddr = POS_W'(list_rdata - ID_W'(1));
		where_wdata = wa_s1;
		if (cmd.sweep_step) begin
			list_we     = 1'b1;
			list_waddr  = sweep_ptr_q;
			list_wdata  = ID_W'(sweep_ptr_q) + ID_W'(1);
			where_we    = 1'b1;
			where_waddr = sweep_ptr_q;
			where_wdata = sweep_ptr_q;
		end else if (cmd.place) begin
			list_we     = 1'b1;
			list_waddr  = dst_q;
			list_wdata  = x_q;
			where_we    = 1'b1;
			where_waddr = POS_W'(x_q - ID_W'(1));
			where_wdata = dst_q;
		end else if (cmd.shift && v_s1) begin
			// The word read last cycle lands one place over, and its id is re-pointed.
			list_we  = 1'b1;
			where_we = 1'b1;
		end
	end

	// Plan the move: the source position, where the item must end and the direction.
	always_comb begin
		plan_src = stat.is_after ? ix_q : where_rdata;
		case (op_q)
			lmre_pkg::OP_FRONT: plan_dst = '0;
			lmre_pkg::OP_BACK:  plan_dst = last_pos;
			default: begin
				if (ix_q > where_rdata) begin
					plan_dst = where_rdata + POS_W'(1);
				end else begin
					plan_dst = where_rdata;
				end
			end
		endcase
		plan_up = plan_src < plan_dst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= MAX_ID;
			sweep_ptr_q <= '0;
			v_s1        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_load) begin
				active_q    <= cfg_clamped;
				sweep_ptr_q <= '0;
			end else if (cmd.sweep_step) begin
				sweep_ptr_q <= sweep_ptr_q + POS_W'(1);
			end
			if (cmd.plan) begin
				cnt_q <= plan_up ? (plan_dst - plan_src) : (plan_src - plan_dst);
				v_s1  <= 1'b0;
			end else if (cmd.shift) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - POS_W'(1);
					v_s1  <= 1'b1;
				end else begin
					v_s1 <= 1'b0;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= lmre_pkg::lmre_op_t'(opcode);
			x_q   <= first_item;
			y_q   <= second_item;
			pos_q <= position;
		end
		if (cmd.latch_ix) begin
			ix_q <= where_rdata;
		end
		if (cmd.plan) begin
			dst_q    <= plan_dst;
			up_q     <= plan_up;
			rd_ptr_q <= plan_up ? (plan_src + POS_W'(1)) : (plan_src - POS_W'(1));
		end else if (cmd.shift && (cnt_q != '0)) begin
			wa_s1    <= up_q ? (rd_ptr_q - POS_W'(1)) : (rd_ptr_q + POS_W'(1));
			rd_ptr_q <= up_q ? (rd_ptr_q + POS_W'(1)) : (rd_ptr_q - POS_W'(1));
		end
		if (cmd.finish) begin
			item_q   <= (stat.is_read && !err) ? list_rdata : '0;
			status_q <= err;
		end
	end

	lmre_ram #(
		.WIDTH(ID_W),
		.DEPTH(MAX_ITEMS)
	) u_list_ram (
		.clk  (clk),
		.we   (list_we),
		.waddr(list_waddr),
		.wdata(list_wdata),
		.re   (list_re),
		.raddr(list_raddr),
		.rdata(list_rdata)
	);

	lmre_ram #(
		.WIDTH(POS_W),
		.DEPTH(MAX_ITEMS)
	) u_where_ram (
		.clk  (clk),
		.we   (where_we),
		.waddr(where_waddr),
		.wdata(where_wdata),
		.re   (where_re),
		.raddr(where_raddr),
		.rdata(where_rdata)
	);

	assign out_valid        = out_valid_q;
	assign item_at_position = item_q;
	assign status           = status_q;

endmodule

[src/list_move_reorder_engine.sv]
// Reorder list engine: keeps a permutation of ids 1..active_count in a list RAM plus an
// id-to-position RAM, and moves an item to the front, to the back or behind another item,
// or reads the id at a position. One word is worked at a time. A move also shifts every
// entry between the item and its new place, one entry at a time, because the list RAM is
// written one entry per cycle. After reset, and after every write of active_count, a reload
// pass (over MAX_ITEMS entries after reset) rebuilds the list in order while input stays
// stalled. Depends on lmre_pkg, lmre_ctrl, lmre_dp and lmre_ram.
`include "list_move_reorder_engine_assert.svh"

module list_move_reorder_engine #(
	parameter int MAX_ITEMS = 1024,
	localparam int ID_W  = $clog2(MAX_ITEMS + 1),
	localparam int POS_W = $clog2(MAX_ITEMS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ID_W-1:0]  cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [ID_W-1:0]  first_item,
	input  logic [ID_W-1:0]  second_item,
	input  logic [POS_W-1:0] position,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ID_W-1:0]  item_at_position,
	output logic             status
);

	lmre_pkg::lmre_cmd_t  cmd;
	lmre_pkg::lmre_stat_t stat;
	logic                 cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	lmre_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cfg_wr  (cfg_wr),
		.stat    (stat),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	lmre_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.first_item      (first_item),
		.second_item     (second_item),
		.position        (position),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.item_at_position(item_at_position),
		.status          (status)
	);

	// Only one word is in flight, so an accepted word stalls the input next cycle.
	`LMRE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second word accepted while busy")
	`LMRE_ASSERT_NEXT(a_cfg_reload, cfg_wr, in_stall, "input open during list reload")
	`LMRE_ASSERT_NOW(a_no_overwrite, cmd.finish, !out_valid || !out_stall, "result overwrote a held word")
	`LMRE_ASSERT_NOW(a_err_zero_item, out_valid && status, item_at_position == '0, "error word carries an id")

endmodule

[bench/list_move_reorder_engine_check.sv]
// Checker for the list reorder engine: watches the config, input and result channels,
// keeps its own copy of the ordered list and compares every result word in order.
// Depends on lmre_pkg for the operation codes.
module list_move_reorder_engine_check
	import lmre_pkg::*;
#(
	parameter int MAX_ITEMS = 1024,
	localparam int ID_W  = $clog2(MAX_ITEMS + 1),
	localparam int POS_W = $clog2(MAX_ITEMS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [ID_W-1:0]  cfg_data,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [ID_W-1:0]  first_item,
	input  logic [ID_W-1:0]  second_item,
	input  logic [POS_W-1:0] position,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [ID_W-1:0]  item_at_position,
	input  logic             status,
	output int               mismatches,
	output int               outstanding
);

	typedef struct {
		logic [ID_W-1:0] item;
		logic            status;
	} reply_t;

	reply_t          replies [$];
	logic [ID_W-1:0] slots [MAX_ITEMS];
	int              list_len;

	function automatic bit id_in_range(logic [ID_W-1:0] id);
		return id >= 1 && id <= list_len;
	endfunction

	function automatic int find_slot(logic [ID_W-1:0] id);
		for (int i = 0; i < list_len; i++)
			if (slots[i] == id)
				return i;
		return list_len;
	endfunction

	// Takes the entry at src out and puts it back so that it ends up at dst.
	task automatic shift_entry(int src, int dst);
		logic [ID_W-1:0] v;
		v = slots[src];
		if (src < dst) begin
			for (int i = src; i < dst; i++)
				slots[i] = slots[i + 1];
		end else begin
			for (int i = src; i > dst; i--)
				slots[i] = slots[i - 1];
		end
		slots[dst] = v;
	endtask

	task automatic reload_list();
		for (int i = 0; i < MAX_ITEMS; i++)
			slots[i] = ID_W'(i + 1);
	endtask

	task automatic predict_word(lmre_op_t op, logic [ID_W-1:0] x, logic [ID_W-1:0] y,
			logic [POS_W-1:0] pos);
		reply_t r;
		int     ix;
		int     iy;
		r.item   = '0;
		r.status = 1'b0;
		if (op == OP_READ) begin
			if (pos < list_len)
				r.item = slots[pos];
			else
				r.status = 1'b1;
		end else if (!id_in_range(x) || (op == OP_AFTER && !id_in_range(y))) begin
			r.status = 1'b1;
		end else begin
			ix = find_slot(x);
			if (ix >= list_len) begin
				r.status = 1'b1;
			end else begin
				case (op)
					OP_FRONT: begin
						shift_entry(ix, 0);
					end
					OP_BACK: begin
						shift_entry(ix, list_len - 1);
					end
					default: begin
						// Placing an item behind itself leaves the list alone.
						if (x != y) begin
							iy = find_slot(y);
							if (iy >= list_len)
								r.status = 1'b1;
							else if (ix > iy)
								shift_entry(ix, iy + 1);
							else
								shift_entry(ix, iy);
						end
					end
				endcase
			end
		end
		replies.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			list_len = MAX_ITEMS;
			reload_list();
			replies.delete();
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies.size() == 0) begin
					$error("result word with nothing outstanding: item_at_position %0d status %0d",
						item_at_position, status);
					mismatches++;
				end else begin
					want = replies.pop_front();
					if (item_at_position !== want.item) begin
						$error("item_at_position: expected %0d, actual %0d", want.item,
							item_at_position);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						mismatches++;
					end
				end
			end
			// A count write clamps to 1..MAX_ITEMS and puts the list back in order.
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == 0)
					list_len = 1;
				else if (cfg_data > MAX_ITEMS)
					list_len = MAX_ITEMS;
				else
					list_len = cfg_data;
				reload_list();
			end
			if (in_valid && !in_stall)
				predict_word(lmre_op_t'(opcode), first_item, second_item, position);
		end
		outstanding = replies.size();
	end

endmodule

[bench/list_move_reorder_engine_test.sv]
// Testbench top for the list reorder engine: drives directed and random list commands
// and count writes with random idling, and gives the verdict from the checker's count.
// Depends on lmre_pkg, list_move_reorder_engine and list_move_reorder_engine_check.
module list_move_reorder_engine_test;
	import lmre_pkg::*;

	localparam int MAX_ITEMS     = 1024;
	localparam int ID_W          = $clog2(MAX_ITEMS + 1);
	localparam int POS_W         = $clog2(MAX_ITEMS);
	localparam int IDLE_LIMIT    = 20000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	localparam int PHASES        = 20;
	localparam int unsigned COUNT_SETTINGS [PHASES] = '{
		2047, 3, 16, 2, 1023, 7, 40, 1, 64, 1500,
		9, 33, 12, 5, 24, 1024, 4, 48, 1025, 20
	};

	typedef struct {
		lmre_op_t         op;
		logic [ID_W-1:0]  x;
		logic [ID_W-1:0]  y;
		logic [POS_W-1:0] pos;
	} list_cmd_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [ID_W-1:0]  cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       opcode = 2'b00;
	logic [ID_W-1:0]  first_item = '0;
	logic [ID_W-1:0]  second_item = '0;
	logic [POS_W-1:0] position = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [ID_W-1:0]  item_at_position;
	logic             status;

	int mismatches;
	int outstanding;
	bit hold_req = 1'b0;
	int burst_left = 0;
	int idle_cycles = 0;

	list_move_reorder_engine #(.MAX_ITEMS(MAX_ITEMS)) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.first_item       (first_item),
		.second_item      (second_item),
		.position         (position),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.item_at_position (item_at_position),
		.status           (status)
	);

	list_move_reorder_engine_check #(.MAX_ITEMS(MAX_ITEMS)) u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.first_item       (first_item),
		.second_item      (second_item),
		.position         (position),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.item_at_position (item_at_position),
		.status           (status),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly ids and positions inside the active list, with some raw field noise.
	function automatic list_cmd_t random_cmd(int len);
		list_cmd_t c;
		c.op = lmre_op_t'($urandom_range(0, 3));
		c.x = ($urandom_range(0, 9) != 0) ? ID_W'($urandom_range(1, len)) : ID_W'($urandom);
		if ($urandom_range(0, 7) == 0)
			c.y = c.x;
		else if ($urandom_range(0, 9) != 0)
			c.y = ID_W'($urandom_range(1, len));
		else
			c.y = ID_W'($urandom);
		c.pos = ($urandom_range(0, 9) != 0) ? POS_W'($urandom_range(0, len - 1))
			: POS_W'($urandom);
		return c;
	endfunction

	// Offers one word, with a random gap at the start of each burst, and
	// returns at the edge where it was taken.
	task automatic offer_word(list_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		opcode      <= c.op;
		first_item  <= c.x;
		second_item <= c.y;
		position    <= c.pos;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send(lmre_op_t op, logic [ID_W-1:0] x, logic [ID_W-1:0] y,
			logic [POS_W-1:0] pos);
		list_cmd_t c;
		c.op  = op;
		c.x   = x;
		c.y   = y;
		c.pos = pos;
		offer_word(c);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_count(logic [ID_W-1:0] v);
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: short stalls, free runs and calm stretches, plus a long hold on request.
	initial begin
		int pick;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 5) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end else if (pick < 9) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end else begin
					out_stall <= 1'b0;
					repeat (60) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int len;
		int items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Full list after reset: both ends, the longest shifts, and bad ids.
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 0);
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 1023);
		send(OP_FRONT, 1024, ID_W'($urandom), POS_W'($urandom));
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 0);
		send(OP_BACK, 1024, ID_W'($urandom), POS_W'($urandom));
		send(OP_AFTER, 1, 1024, POS_W'($urandom));
		send(OP_AFTER, 1, 2, POS_W'($urandom));
		send(OP_AFTER, 7, 7, POS_W'($urandom));
		send(OP_FRONT, 0, ID_W'($urandom), POS_W'($urandom));
		send(OP_BACK, 1025, ID_W'($urandom), POS_W'($urandom));
		send(OP_AFTER, 3, 0, POS_W'($urandom));
		send(OP_AFTER, 2047, 3, POS_W'($urandom));
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 2);

		// A zero count clamps to a single item.
		write_count(0);
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 0);
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 1);
		send(OP_FRONT, 1, ID_W'($urandom), POS_W'($urandom));
		send(OP_BACK, 1, ID_W'($urandom), POS_W'($urandom));
		send(OP_AFTER, 1, 1, POS_W'($urandom));
		send(OP_AFTER, 1, 2, POS_W'($urandom));
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 1023);

		write_count(2);
		send(OP_AFTER, 1, 2, POS_W'($urandom));
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 0);
		send(OP_READ, ID_W'($urandom), ID_W'($urandom), 1);
		send(OP_FRONT, 2, ID_W'($urandom), POS_W'($urandom));

		for (int p = 0; p < PHASES; p++) begin
			write_count(ID_W'(COUNT_SETTINGS[p]));
			if (COUNT_SETTINGS[p] == 0)
				len = 1;
			else if (COUNT_SETTINGS[p] > MAX_ITEMS)
				len = MAX_ITEMS;
			else
				len = COUNT_SETTINGS[p];
			// Long lists shift up to a whole list per word, so they get fewer words.
			items = (len >= 1000) ? 40 : 95;
			if (p == 2 || p == 11)
				hold_req = 1'b1;
			repeat (items) offer_word(random_cmd(len));
		end

		drain_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
